FILE: design/prefix_code_table_decoder_top_assert.svh
// Assertion macros shared by the prefix code table decoder RTL.
`ifndef PREFIX_CODE_TABLE_DECODER_TOP_ASSERT_SVH
`define PREFIX_CODE_TABLE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCTD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/pctd_pkg.sv
// Types and constants of the prefix code table decoder.
package pctd_pkg;

    localparam int SYM_W  = 9;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int CNT_W  = 6;
    localparam int OUT_W  = 8;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_DECODE = 1'b1;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_entry;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN
    } t_state;

endpackage

FILE: design/prefix_code_table_decoder_top.sv
// Prefix code table decoder: table memory, bit accumulator and scan control.
//
// Usage
//   Input beats use a command handshake: a beat is taken at a rising edge with
//   start high and busy low. A load beat (i_kind = 0) writes one table entry
//   (code, length) at index i_entry_symbol; indexes at or past NUM_ENTRIES are
//   dropped. A decode beat (i_kind = 1) shifts i_code_bit into the accumulator.
//   Load and decode
//   A load leaves busy low. A decode walks the table through one synchronous
//   single-read-port memory, one entry per cycle from index 0 upward, and
//   stops at the first hit. It holds busy until the scan ends; the result
//   beat appears in the same cycle that busy falls.
//   The memory read port sets the scan rate: one entry per cycle.
//   Results
//   At most one result beat per decode: o_strobe high for one cycle with the
//   symbol, the end-of-message flag, or the overflow flag. The receiver cannot
//   stall; each result beat is taken on the cycle it is shown.
//   Reset
//   i_rst_n is synchronous, active low. After reset a clearing pass empties
//   every entry; busy stays high until it ends.
module prefix_code_table_decoder_top #(
    parameter int MAX_CODE_LEN = 32,
    parameter int NUM_ENTRIES  = 257
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_kind,
    input  logic [pctd_pkg::SYM_W-1:0]  i_entry_symbol,
    input  logic [pctd_pkg::CODE_W-1:0] i_entry_code,
    input  logic [pctd_pkg::LEN_W-1:0]  i_entry_length,
    input  logic                      i_code_bit,
    output logic                      o_strobe,
    output logic [pctd_pkg::OUT_W-1:0]  o_symbol,
    output logic                      o_end_of_message,
    output logic                      o_overflow_error
);

`include "prefix_code_table_decoder_top_assert.svh"

    localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int AW = MAX_CODE_LEN;
    localparam int EW = (MAX_CODE_LEN > pctd_pkg::CODE_W) ? MAX_CODE_LEN : pctd_pkg::CODE_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_ENTRIES - 1);
    localparam logic [pctd_pkg::CNT_W:0] MAX_LEN_C = (pctd_pkg::CNT_W + 1)'(MAX_CODE_LEN);

    // Table memory: code and length per entry, one write and one read port.
    pctd_pkg::t_entry r_mem [NUM_ENTRIES];

    pctd_pkg::t_state r_state, n_state;
    logic [IW-1:0]    r_addr, n_addr;
    logic             r_issue, n_issue;
    logic             r_rd_vld, n_rd_vld;
    logic [IW-1:0]    r_rd_idx, n_rd_idx;
    pctd_pkg::t_entry r_rd_data;
    logic [AW-1:0]    r_acc, n_acc;
    logic [pctd_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic             r_strobe, n_strobe;
    logic [pctd_pkg::OUT_W-1:0] r_sym, n_sym;
    logic             r_eom, n_eom;
    logic             r_ovf, n_ovf;

    logic             rd_en;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    pctd_pkg::t_entry wr_data;

    logic [EW-1:0]    code_ext;
    logic [EW-1:0]    acc_ext;
    logic [EW-1:0]    len_mask;
    logic             hit;

    // Memory ports.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    // Compare the fetched entry against the accumulated bits.
    always_comb begin
        code_ext = EW'(r_rd_data.code);
        acc_ext  = EW'(r_acc);
        for (int k = 0; k < EW; k++) begin
            len_mask[k] = (k < int'(r_rd_data.len));
        end
        hit = (r_rd_data.len != '0)
              && ({1'b0, r_rd_data.len} <= MAX_LEN_C)
              && (r_rd_data.len == r_cnt)
              && ((code_ext & len_mask) == acc_ext);
    end

    // Next state and datapath control.
    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_issue  = r_issue;
        n_rd_vld = 1'b0;
        n_rd_idx = r_addr;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_strobe = 1'b0;
        n_sym    = '0;
        n_eom    = 1'b0;
        n_ovf    = 1'b0;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = r_addr;
        wr_data  = '0;
        case (r_state)
            pctd_pkg::ST_CLEAR: begin
                // Empty one entry per cycle.
                wr_en = 1'b1;
                if (r_addr == LAST_IDX) begin
                    n_state = pctd_pkg::ST_IDLE;
                    n_addr  = '0;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            pctd_pkg::ST_IDLE: begin
                if (start) begin
                    if (i_kind == pctd_pkg::KIND_LOAD) begin
                        // Drop loads past the end of the table.
                        wr_en        = (int'(i_entry_symbol) < NUM_ENTRIES);
                        wr_addr      = IW'(i_entry_symbol);
                        wr_data.code = i_entry_code;
                        wr_data.len  = i_entry_length;
                    end else begin
                        n_acc   = AW'({r_acc, i_code_bit});
                        n_cnt   = r_cnt + 1'b1;
                        n_state = pctd_pkg::ST_SCAN;
                        n_addr  = '0;
                        n_issue = 1'b1;
                    end
                end
            end
            pctd_pkg::ST_SCAN: begin
                if (r_issue) begin
                    rd_en    = 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_addr;
                    if (r_addr == LAST_IDX) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
                if (r_rd_vld) begin
                    if (hit) begin
                        // First hit wins; drop reads still in flight.
                        n_strobe = 1'b1;
                        n_eom    = (r_rd_idx == LAST_IDX);
                        n_sym    = (r_rd_idx == LAST_IDX) ? '0 : pctd_pkg::OUT_W'(r_rd_idx);
                        n_acc    = '0;
                        n_cnt    = '0;
                        n_issue  = 1'b0;
                        n_rd_vld = 1'b0;
                        n_state  = pctd_pkg::ST_IDLE;
                    end else if (r_rd_idx == LAST_IDX) begin
                        if ({1'b0, r_cnt} >= MAX_LEN_C) begin
                            n_strobe = 1'b1;
                            n_ovf    = 1'b1;
                            n_acc    = '0;
                            n_cnt    = '0;
                        end
                        n_rd_vld = 1'b0;
                        n_state  = pctd_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = pctd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pctd_pkg::ST_CLEAR;
            r_addr   <= '0;
            r_issue  <= 1'b0;
            r_rd_vld <= 1'b0;
            r_acc    <= '0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_issue  <= n_issue;
            r_rd_vld <= n_rd_vld;
            r_acc    <= n_acc;
            r_cnt    <= n_cnt;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_rd_idx <= n_rd_idx;
        r_sym    <= n_sym;
        r_eom    <= n_eom;
        r_ovf    <= n_ovf;
    end

    assign busy             = (r_state != pctd_pkg::ST_IDLE);
    assign o_strobe         = r_strobe;
    assign o_symbol         = r_sym;
    assign o_end_of_message = r_eom;
    assign o_overflow_error = r_ovf;

    // A result beat only ends a scan.
    `PCTD_ASSERT_NOW(a_strobe_after_scan, i_clk, i_rst_n, o_strobe, $past(r_state) == pctd_pkg::ST_SCAN, "result without scan")
    // Every result clears the accumulator.
    `PCTD_ASSERT_NOW(a_strobe_clears, i_clk, i_rst_n, o_strobe, (r_cnt == '0) && (r_acc == '0), "accumulator not cleared")
    // Overflow carries no symbol and no end flag.
    `PCTD_ASSERT_NOW(a_ovf_clean, i_clk, i_rst_n, o_strobe && o_overflow_error, (o_symbol == '0) && !o_end_of_message, "overflow payload")
    // The bit count never passes the longest code.
    `PCTD_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, {1'b0, r_cnt} <= MAX_LEN_C, "count past limit")
    // An accepted decode beat always starts a scan.
    `PCTD_ASSERT_NEXT(a_decode_scans, i_clk, i_rst_n, start && !busy && (i_kind == pctd_pkg::KIND_DECODE), r_state == pctd_pkg::ST_SCAN, "decode did not scan")

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the prefix code table decoder: random code tables and bit streams.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CODE_LEN = 32;
    localparam int NUM_ENTRIES  = 257;
    localparam int END_INDEX    = NUM_ENTRIES - 1;
    localparam int RANDOM_ITEMS = 1250;
    // Worst case per beat: full table scan plus the longest idle gap, for fewer
    // than 2000 beats. Take that several times over.
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int PRINT_CAP    = 100;

    // One decoded result beat as seen on the output ports.
    typedef struct packed {
        logic [pctd_pkg::OUT_W-1:0] symbol;
        logic                       end_flag;
        logic                       overflow;
    } t_decoded;

    // Code table and bit accumulator mirror; queues the decode results they imply.
    class decode_scoreboard;
        logic [pctd_pkg::CODE_W-1:0] entry_code [NUM_ENTRIES];
        logic [pctd_pkg::LEN_W-1:0]  entry_len  [NUM_ENTRIES];
        logic [MAX_CODE_LEN-1:0]     bit_acc;
        int unsigned                 bit_count;
        t_decoded                    expected_q[$];
        int                          mismatches;

        function new();
            foreach (entry_len[i]) begin
                entry_len[i]  = '0;
                entry_code[i] = '0;
            end
            bit_acc    = '0;
            bit_count  = 0;
            mismatches = 0;
        endfunction

        task report(string msg);
            // Keep the log short when the block is badly off.
            if (mismatches < PRINT_CAP) begin
                $display("MISMATCH @%0t: %s", $time, msg);
            end
            mismatches++;
        endtask

        // Note one accepted input beat and queue the result it causes, if any.
        function void note_beat(logic kind, logic [pctd_pkg::SYM_W-1:0] sym,
                                logic [pctd_pkg::CODE_W-1:0] code,
                                logic [pctd_pkg::LEN_W-1:0] len, logic cbit);
            logic [MAX_CODE_LEN-1:0] mask;
            int unsigned             l;
            t_decoded                hit;
            if (kind == pctd_pkg::KIND_LOAD) begin
                if (sym < NUM_ENTRIES) begin
                    entry_code[sym] = code;
                    entry_len[sym]  = len;
                end
                return;
            end
            bit_acc   = {bit_acc[MAX_CODE_LEN-2:0], cbit};
            bit_count = bit_count + 1;
            // Scan from the lowest index; the first entry of matching length and code wins.
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                l = 32'(entry_len[i]);
                if (l != 0 && l <= MAX_CODE_LEN && l == bit_count) begin
                    mask = '1;
                    mask = mask >> (MAX_CODE_LEN - l);
                    if ((entry_code[i] & mask) == bit_acc) begin
                        hit.symbol   = (i == END_INDEX) ? '0 : i[pctd_pkg::OUT_W-1:0];
                        hit.end_flag = (i == END_INDEX);
                        hit.overflow = 1'b0;
                        expected_q.push_back(hit);
                        bit_acc   = '0;
                        bit_count = 0;
                        return;
                    end
                end
            end
            if (bit_count >= MAX_CODE_LEN) begin
                hit.symbol   = '0;
                hit.end_flag = 1'b0;
                hit.overflow = 1'b1;
                expected_q.push_back(hit);
                bit_acc   = '0;
                bit_count = 0;
            end
        endfunction

        // Compare one result beat against the oldest expectation.
        task check_result(logic [pctd_pkg::OUT_W-1:0] sym, logic eom, logic ovf);
            t_decoded want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result symbol=%0d end=%b overflow=%b",
                                 sym, eom, ovf));
                return;
            end
            want = expected_q.pop_front();
            if (sym !== want.symbol)
                report($sformatf("symbol %0d, expected %0d", sym, want.symbol));
            if (eom !== want.end_flag)
                report($sformatf("end_of_message %b, expected %b", eom, want.end_flag));
            if (ovf !== want.overflow)
                report($sformatf("overflow_error %b, expected %b", ovf, want.overflow));
        endtask
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic                          i_kind = pctd_pkg::KIND_LOAD;
    logic [pctd_pkg::SYM_W-1:0]    i_entry_symbol = '0;
    logic [pctd_pkg::CODE_W-1:0]   i_entry_code = '0;
    logic [pctd_pkg::LEN_W-1:0]    i_entry_length = '0;
    logic                          i_code_bit = 1'b0;
    logic                          o_strobe;
    logic [pctd_pkg::OUT_W-1:0]    o_symbol;
    logic                          o_end_of_message;
    logic                          o_overflow_error;

    decode_scoreboard sb = new();

    // What the stimulus has written to the table, so messages can be built from it.
    logic [pctd_pkg::CODE_W-1:0]   loaded_code [NUM_ENTRIES];
    logic [pctd_pkg::LEN_W-1:0]    loaded_len  [NUM_ENTRIES];
    int                            idle_mode;
    int                            random_items;
    int                            cycle_count = 0;

    prefix_code_table_decoder_top #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .NUM_ENTRIES  (NUM_ENTRIES)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_kind           (i_kind),
        .i_entry_symbol   (i_entry_symbol),
        .i_entry_code     (i_entry_code),
        .i_entry_length   (i_entry_length),
        .i_code_bit       (i_code_bit),
        .o_strobe         (o_strobe),
        .o_symbol         (o_symbol),
        .o_end_of_message (o_end_of_message),
        .o_overflow_error (o_overflow_error)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Sample both sides at the edge. Check the result first so a beat accepted on
    // the same edge queues behind the expectation that is being retired.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe !== 1'b0) begin
                sb.check_result(o_symbol, o_end_of_message, o_overflow_error);
            end
            if (start && !busy) begin
                sb.note_beat(i_kind, i_entry_symbol, i_entry_code, i_entry_length, i_code_bit);
            end
        end
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Idle gap ahead of the next beat: mostly none or short, a few long enough to
    // outlast a full table scan. Mode zero runs back to back.
    function automatic int pick_gap();
        int r;
        if (idle_mode == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(10, 60);
        return $urandom_range(100, 300);
    endfunction

    // Present one beat and hold it until the block takes it.
    task automatic send_beat(logic kind, logic [pctd_pkg::SYM_W-1:0] sym,
                             logic [pctd_pkg::CODE_W-1:0] code,
                             logic [pctd_pkg::LEN_W-1:0] len, logic cbit);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_kind         <= kind;
        i_entry_symbol <= sym;
        i_entry_code   <= code;
        i_entry_length <= len;
        i_code_bit     <= cbit;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (kind == pctd_pkg::KIND_DECODE || sym < NUM_ENTRIES)
            random_items++;
    endtask

    task automatic load_entry(int sym, logic [pctd_pkg::CODE_W-1:0] code, int len);
        if (sym < NUM_ENTRIES) begin
            loaded_code[sym] = code;
            loaded_len[sym]  = pctd_pkg::LEN_W'(len);
        end
        send_beat(pctd_pkg::KIND_LOAD, pctd_pkg::SYM_W'(sym), code, pctd_pkg::LEN_W'(len),
                  1'($urandom_range(0, 1)));
    endtask

    // Decode beats carry random junk in the load fields.
    task automatic decode_bit(logic b);
        send_beat(pctd_pkg::KIND_DECODE, pctd_pkg::SYM_W'($urandom_range(0, 511)), $urandom,
                  pctd_pkg::LEN_W'($urandom_range(0, 63)), b);
    endtask

    // Pick a code length for the table style of a phase.
    function automatic int pick_length(int style);
        int r;
        r = $urandom_range(0, 99);
        if (style == 9) begin
            // Mostly entries that can never match, so noise runs into overflow.
            if (r < 40) return $urandom_range(33, 63);
            if (r < 70) return 0;
            return MAX_CODE_LEN;
        end
        if (style >= 7)
            return (r < 50) ? MAX_CODE_LEN : $urandom_range(20, 31);
        if (r < 85) return $urandom_range(1, 6);
        if (r < 95) return $urandom_range(7, 16);
        if (r < 98) return $urandom_range(33, 63);
        return 0;
    endfunction

    // One phase: empty the old table, load a new one, then stream messages.
    task automatic run_phase();
        int  style, n, m, sym, len, cut, noise;
        int  used_syms[$];
        bit  sent;
        idle_mode = $urandom_range(0, 3);
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (loaded_len[i] != 0)
                load_entry(i, $urandom, 0);
        end
        style = $urandom_range(0, 9);
        n = (style == 9) ? $urandom_range(1, 3) : $urandom_range(2, 12);
        repeat (n) begin
            sym = ($urandom_range(0, 7) == 0) ? END_INDEX : $urandom_range(0, 255);
            // Now and then aim past the table; the block must drop it.
            if ($urandom_range(0, 19) == 0)
                sym = $urandom_range(NUM_ENTRIES, 511);
            load_entry(sym, $urandom, pick_length(style));
            if (sym < NUM_ENTRIES)
                used_syms.push_back(sym);
        end
        m = $urandom_range(4, 24);
        repeat (m) begin
            // Stop streaming once the run has its beats.
            if (random_items >= RANDOM_ITEMS)
                break;
            sent = 1'b0;
            if (used_syms.size() > 0 && $urandom_range(0, 99) < 85) begin
                sym = used_syms[$urandom_range(0, used_syms.size() - 1)];
                len = int'(loaded_len[sym]);
                if (len >= 1 && len <= MAX_CODE_LEN) begin
                    // Send the code first bit first; sometimes cut it short.
                    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : len;
                    for (int b = len - 1; b >= len - cut; b--)
                        decode_bit(loaded_code[sym][b]);
                    sent = 1'b1;
                end
            end
            if (!sent) begin
                noise = (style == 9) ? $urandom_range(30, 40) : $urandom_range(1, 8);
                repeat (noise) decode_bit(1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        random_items = 0;
        idle_mode    = 0;
        foreach (loaded_len[i]) begin
            loaded_len[i]  = '0;
            loaded_code[i] = '0;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a complete code {0, 10, 11=end} with the corner cases around it.
        idle_mode = 1;
        load_entry(END_INDEX, 32'h0000_0003, 2);
        load_entry(0, 32'hFFFF_FFFE, 1);       // junk above the length must be ignored
        load_entry(5, 32'h0000_0002, 2);
        load_entry(200, 32'h0000_0002, 2);     // duplicate code, index 5 must win
        load_entry(511, 32'hFFFF_FFFF, 63);    // past the table, dropped
        load_entry(300, 32'h0000_0000, 1);     // past the table, would shadow symbol 0
        load_entry(7, 32'h0000_0000, 33);      // overlong, never matches
        load_entry(9, 32'h5555_5555, 0);       // empty
        decode_bit(1'b0);
        decode_bit(1'b1);
        decode_bit(1'b0);
        decode_bit(1'b1);
        decode_bit(1'b1);
        load_entry(5, 32'h0000_0000, 0);       // drop symbol 5; "10" now decodes as symbol 200
        decode_bit(1'b1);
        decode_bit(1'b0);
        decode_bit(1'b1);
        decode_bit(1'b1);

        // Random phases until enough beats went in.
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
            run_phase();

        // Drain: wait for every expected beat and an idle block, then a full scan more.
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0 || busy) @(posedge i_clk);
        repeat (NUM_ENTRIES + 8) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
